[rtl/core/bitmap_shape_draw_engine_macros.svh]
// Assertion macros for the drawing engine.
`ifndef BITMAP_SHAPE_DRAW_ENGINE_MACROS_SVH
`define BITMAP_SHAPE_DRAW_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define BSDE_ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bitmap_shape_draw_engine: assertion failed");
`define BSDE_ASSERT(name, prop) \
   `BSDE_ASSERT_CLK(name, clock, reset, prop)
`else
`define BSDE_ASSERT_CLK(name, clk, rst, prop)
`define BSDE_ASSERT(name, prop)
`endif

`endif

[rtl/core/bsde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsde_pkg;

   localparam int CMD_W      = 3;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 5;
   localparam int SIZE_W     = 6;
   // row/column positions: start plus size, up to 31 + 63
   localparam int POS_W      = 7;
   localparam int ROW_BITS_W = 32;
   localparam int MAX_COLS   = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 3'd0,
      CMD_OUTLINE = 3'd1,
      CMD_FILL    = 3'd2,
      CMD_HLINE   = 3'd3,
      CMD_VLINE   = 3'd4,
      CMD_READ    = 3'd5
   } cmd_type;

endpackage

`default_nettype wire

[rtl/core/bsde_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

[rtl/core/bitmap_shape_draw_engine.sv]
// One-bit-per-pixel screen with drawing commands.
// Input channel req_*: one command word per handshake (clear, outline rect,
// filled rect, hline, vline, read row). Result channel rsp_*: exactly one
// word per command; rsp_row_bits holds the row for a read, zero otherwise.
// Shapes are clipped at the screen edges; a zero size draws nothing.
// A command walks the rows it touches through the row RAM: one row read per
// cycle, each drawn row written back (OR with the column mask) the cycle after.
// When its rows are done and the output register is free, the result word
// is loaded into that register and the engine returns to idle, ready for
// the next command, in the same cycle. A command touching no row (clear,
// unused codes, zero sizes) goes straight to its result; clear drops every
// row's valid bit at once. A read touches one row.
// One command is in work at a time. The result sits in an output register;
// the next command runs while that word waits, and only the hand-off of its
// own result waits for rsp_ready.
// Reset (synchronous) marks every row as blank and empties the output.
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_shape_draw_engine_macros.svh"

module bitmap_shape_draw_engine #(
   parameter int SCREEN_ROWS = 32,
   parameter int SCREEN_COLS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [bsde_pkg::CMD_W-1:0]       req_cmd,
   input  wire logic [bsde_pkg::ROW_W-1:0]       req_start_row,
   input  wire logic [bsde_pkg::COL_W-1:0]       req_start_col,
   input  wire logic [bsde_pkg::SIZE_W-1:0]      req_rect_width,
   input  wire logic [bsde_pkg::SIZE_W-1:0]      req_rect_height,
   input  wire logic [bsde_pkg::SIZE_W-1:0]      req_line_length,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [bsde_pkg::ROW_BITS_W-1:0]       rsp_row_bits,
   output logic                                  rsp_is_read
);

   localparam int RowAW = $clog2(SCREEN_ROWS);
   localparam int PosW  = bsde_pkg::POS_W;
   localparam int BitsW = bsde_pkg::ROW_BITS_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_RUN    = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // control
   state_type              state_ff, state_in;
   logic [SCREEN_ROWS-1:0] valid_ff, valid_in;
   logic                   pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // command context
   logic [PosW-1:0]        y_ff, y_in;
   logic [PosW-1:0]        end_ff, end_in;
   logic [PosW-1:0]        first_ff, first_in;
   logic [PosW-1:0]        last_ff, last_in;
   logic [PosW-1:0]        pend_pos_ff, pend_pos_in;
   logic                   outline_ff, outline_in;
   logic                   is_read_ff, is_read_in;
   logic [SCREEN_COLS-1:0] span_ff, span_in;
   logic [SCREEN_COLS-1:0] side_ff, side_in;
   logic [BitsW-1:0]       res_bits_ff, res_bits_in;
   logic [BitsW-1:0]       rsp_bits_ff, rsp_bits_in;
   logic                   rsp_is_read_ff, rsp_is_read_in;

   // decode
   logic [bsde_pkg::SIZE_W-1:0] dec_ncol;
   logic [bsde_pkg::SIZE_W-1:0] dec_nrow;
   logic [PosW-1:0]             dec_c;
   logic [PosW-1:0]             dec_r;
   logic [PosW-1:0]             dec_col_end;
   logic [PosW-1:0]             dec_right;
   logic [SCREEN_COLS-1:0]      dec_span;
   logic [SCREEN_COLS-1:0]      dec_edge;
   logic                        dec_outline;

   // row RAM
   logic                   ram_we, ram_re;
   logic [RowAW-1:0]       ram_waddr, ram_raddr;
   logic [SCREEN_COLS-1:0] ram_wdata, ram_rdata;

   logic                          issue;
   logic [SCREEN_COLS-1:0]        old_row;
   logic [bsde_pkg::MAX_COLS-1:0] old_wide;
   logic [SCREEN_COLS-1:0]        row_mask;

   bsde_ram #(
      .WIDTH(SCREEN_COLS),
      .DEPTH(SCREEN_ROWS)
   ) u_rows (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      dec_outline = 1'b0;
      dec_ncol    = '0;
      dec_nrow    = '0;
      unique case (req_cmd)
         bsde_pkg::CMD_OUTLINE: begin
            dec_outline = 1'b1;
            dec_ncol    = req_rect_width;
            if (req_rect_width != '0 && req_rect_height != '0) begin
               dec_nrow = req_rect_height;
            end
         end
         bsde_pkg::CMD_FILL: begin
            dec_ncol = req_rect_width;
            if (req_rect_width != '0 && req_rect_height != '0) begin
               dec_nrow = req_rect_height;
            end
         end
         bsde_pkg::CMD_HLINE: begin
            dec_ncol = req_line_length;
            if (req_line_length != '0) begin
               dec_nrow = bsde_pkg::SIZE_W'(1);
            end
         end
         bsde_pkg::CMD_VLINE: begin
            dec_ncol = bsde_pkg::SIZE_W'(1);
            dec_nrow = req_line_length;
         end
         bsde_pkg::CMD_READ: begin
            dec_nrow = bsde_pkg::SIZE_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign dec_c       = PosW'(req_start_col);
   assign dec_r       = PosW'(req_start_row);
   assign dec_col_end = dec_c + PosW'(dec_ncol);
   assign dec_right   = dec_c + PosW'(req_rect_width) - PosW'(1);

   // per-column masks; columns past the screen simply do not exist
   always_comb begin
      for (int x = 0; x < SCREEN_COLS; x++) begin
         dec_span[x] = (PosW'(x) >= dec_c) && (PosW'(x) < dec_col_end);
         dec_edge[x] = (PosW'(x) == dec_c) || (PosW'(x) == dec_right);
      end
   end

   assign issue     = (state_ff == ST_RUN) && (y_ff != end_ff)
                      && (int'(y_ff) < SCREEN_ROWS);
   assign ram_re    = issue;
   assign ram_raddr = RowAW'(y_ff);
   assign ram_waddr = RowAW'(pend_pos_ff);

   // a row never written since the last clear reads as blank
   assign old_row   = valid_ff[ram_waddr] ? ram_rdata : '0;
   assign old_wide  = bsde_pkg::MAX_COLS'(old_row);
   assign row_mask  = (!outline_ff || pend_pos_ff == first_ff || pend_pos_ff == last_ff)
                      ? span_ff : side_ff;
   assign ram_wdata = old_row | row_mask;
   assign ram_we    = pend_ff && !is_read_ff;

   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      pend_in        = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      y_in           = y_ff;
      end_in         = end_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      pend_pos_in    = pend_pos_ff;
      outline_in     = outline_ff;
      is_read_in     = is_read_ff;
      span_in        = span_ff;
      side_in        = side_ff;
      res_bits_in    = res_bits_ff;
      rsp_bits_in    = rsp_bits_ff;
      rsp_is_read_in = rsp_is_read_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               y_in        = dec_r;
               end_in      = dec_r + PosW'(dec_nrow);
               first_in    = dec_r;
               last_in     = dec_r + PosW'(req_rect_height) - PosW'(1);
               outline_in  = dec_outline;
               is_read_in  = (req_cmd == bsde_pkg::CMD_READ);
               span_in     = dec_span;
               side_in     = dec_outline ? dec_edge : dec_span;
               res_bits_in = '0;
               if (req_cmd == bsde_pkg::CMD_CLEAR) begin
                  valid_in = '0;
               end
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue) begin
               pend_in     = 1'b1;
               pend_pos_in = y_ff;
               y_in        = y_ff + PosW'(1);
            end
            if (pend_ff) begin
               if (is_read_ff) begin
                  res_bits_in = old_wide[BitsW-1:0];
               end else begin
                  valid_in[ram_waddr] = 1'b1;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_bits_in    = res_bits_ff;
               rsp_is_read_in = is_read_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff           <= y_in;
      end_ff         <= end_in;
      first_ff       <= first_in;
      last_ff        <= last_in;
      pend_pos_ff    <= pend_pos_in;
      outline_ff     <= outline_in;
      is_read_ff     <= is_read_in;
      span_ff        <= span_in;
      side_ff        <= side_in;
      res_bits_ff    <= res_bits_in;
      rsp_bits_ff    <= rsp_bits_in;
      rsp_is_read_ff <= rsp_is_read_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row_bits = rsp_bits_ff;
   assign rsp_is_read  = rsp_is_read_ff;

   // write-back of one row never collides with the read of the next
   `BSDE_ASSERT(a_no_row_overlap, ram_we && ram_re |-> ram_waddr != ram_raddr)
   // read data is consumed only while a command walks its rows
   `BSDE_ASSERT(a_pend_in_run, pend_ff |-> state_ff == ST_RUN)
   // a blocked output word holds the finished command back
   `BSDE_ASSERT(a_finish_waits, state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready |=> state_ff == ST_FINISH)
   // only read words carry row data
   `BSDE_ASSERT(a_draw_word_zero, rsp_valid && !rsp_is_read |-> rsp_row_bits == '0)

endmodule

`default_nettype wire

[bench/bitmap_draw_checker.sv]
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the screen and checks every
// result word against the prediction made when its command was accepted.
module bitmap_draw_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [bsde_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [bsde_pkg::ROW_W-1:0]     req_start_row,
   input  wire logic [bsde_pkg::COL_W-1:0]     req_start_col,
   input  wire logic [bsde_pkg::SIZE_W-1:0]    req_rect_width,
   input  wire logic [bsde_pkg::SIZE_W-1:0]    req_rect_height,
   input  wire logic [bsde_pkg::SIZE_W-1:0]    req_line_length,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic [bsde_pkg::ROW_BITS_W-1:0] rsp_row_bits,
   input  wire logic                           rsp_is_read,
   output int                                  fail_count,
   output int                                  pending_words
);
   import bsde_pkg::*;

   localparam int SCREEN_ROWS = 32;
   localparam int SCREEN_COLS = 32;

   typedef struct packed {
      logic [ROW_BITS_W-1:0] row_bits;
      logic                  is_read;
   } rsp_word_type;

   logic [SCREEN_COLS-1:0] screen [SCREEN_ROWS];
   rsp_word_type           expected_words [$];

   initial begin
      fail_count = 0;
      pending_words = 0;
   end

   // columns first..first+count-1, clipped at the right edge
   function automatic logic [SCREEN_COLS-1:0] col_mask(input int first, input int count);
      logic [SCREEN_COLS-1:0] m;
      int stop;
      m = '0;
      stop = first + count;
      if (stop > SCREEN_COLS) stop = SCREEN_COLS;
      for (int x = 0; x < SCREEN_COLS; x++)
         if (x >= first && x < stop) m[x] = 1'b1;
      return m;
   endfunction

   function automatic void paint_rows(input int first, input int count,
                                      input logic [SCREEN_COLS-1:0] mask);
      for (int y = first; y < first + count && y < SCREEN_ROWS; y++)
         screen[y] |= mask;
   endfunction

   // applies one command to the shadow screen, returns the word it answers with
   function automatic rsp_word_type draw_command(
      input logic [CMD_W-1:0] cmd, input int r, input int c,
      input int w, input int h, input int len);
      rsp_word_type word;
      word = '0;
      case (cmd)
         CMD_CLEAR: begin
            for (int y = 0; y < SCREEN_ROWS; y++) screen[y] = '0;
         end
         CMD_OUTLINE: begin
            if (w != 0 && h != 0) begin
               paint_rows(r, h, col_mask(c, 1) | col_mask(c + w - 1, 1));
               paint_rows(r, 1, col_mask(c, w));
               paint_rows(r + h - 1, 1, col_mask(c, w));
            end
         end
         CMD_FILL: begin
            if (w != 0 && h != 0) paint_rows(r, h, col_mask(c, w));
         end
         CMD_HLINE: begin
            if (len != 0) paint_rows(r, 1, col_mask(c, len));
         end
         CMD_VLINE: begin
            if (len != 0) paint_rows(r, len, col_mask(c, 1));
         end
         CMD_READ: begin
            word.is_read = 1'b1;
            if (r < SCREEN_ROWS) word.row_bits = screen[r];
         end
         default: ;
      endcase
      return word;
   endfunction

   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (reset) begin
         for (int y = 0; y < SCREEN_ROWS; y++) screen[y] = '0;
         expected_words.delete();
      end else begin
         if (req_valid && req_ready)
            expected_words.push_back(draw_command(req_cmd, int'(req_start_row),
               int'(req_start_col), int'(req_rect_width), int'(req_rect_height),
               int'(req_line_length)));
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word: row_bits %h is_read %b",
                      rsp_row_bits, rsp_is_read);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_row_bits !== want.row_bits) begin
                  $error("row_bits: expected %h, actual %h", want.row_bits, rsp_row_bits);
                  fail_count++;
               end
               if (rsp_is_read !== want.is_read) begin
                  $error("is_read: expected %b, actual %b", want.is_read, rsp_is_read);
                  fail_count++;
               end
            end
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
   import bsde_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
   localparam int RANDOM_WORDS = 1150;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [CMD_W-1:0]        req_cmd;
   logic [ROW_W-1:0]        req_start_row;
   logic [COL_W-1:0]        req_start_col;
   logic [SIZE_W-1:0]       req_rect_width;
   logic [SIZE_W-1:0]       req_rect_height;
   logic [SIZE_W-1:0]       req_line_length;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [ROW_BITS_W-1:0]   rsp_row_bits;
   logic                    rsp_is_read;
   int                      fail_count;
   int                      pending_words;
   int                      cycle_count;
   bit                      quiet;

   bitmap_shape_draw_engine DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_start_row(req_start_row), .req_start_col(req_start_col),
      .req_rect_width(req_rect_width), .req_rect_height(req_rect_height),
      .req_line_length(req_line_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_row_bits(rsp_row_bits), .rsp_is_read(rsp_is_read)
   );

   bitmap_draw_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_start_row(req_start_row), .req_start_col(req_start_col),
      .req_rect_width(req_rect_width), .req_rect_height(req_rect_height),
      .req_line_length(req_line_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_row_bits(rsp_row_bits), .rsp_is_read(rsp_is_read),
      .fail_count(fail_count), .pending_words(pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // mostly short gaps, now and then a long one; none while quiet
   function automatic int idle_cycles();
      int pick;
      if (quiet) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // sizes lean small so the screen does not fill up between clears
   function automatic logic [SIZE_W-1:0] pick_size();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return SIZE_W'($urandom_range(0, 8));
      if (pick < 92) return SIZE_W'($urandom_range(0, 32));
      return SIZE_W'($urandom_range(0, 63));
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3)  return CMD_CLEAR;
      if (pick < 17) return CMD_OUTLINE;
      if (pick < 27) return CMD_FILL;
      if (pick < 42) return CMD_HLINE;
      if (pick < 57) return CMD_VLINE;
      if (pick < 95) return CMD_READ;
      if (pick < 97) return CMD_SPARE_A;
      return CMD_SPARE_B;
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic [SIZE_W-1:0] w,
                            input logic [SIZE_W-1:0] h, input logic [SIZE_W-1:0] len);
      int gap;
      gap = idle_cycles();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_start_row   <= row;
      req_start_col   <= col;
      req_rect_width  <= w;
      req_rect_height <= h;
      req_line_length <= len;
      do @(posedge clock); while (!req_ready);
   endtask

   // result side backpressure
   initial begin
      int stall;
      int hold;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         hold = $urandom_range(1, 12);
         repeat (hold) @(negedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [CMD_W-1:0] cmd;
      quiet           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_CLEAR;
      req_start_row   = '0;
      req_start_col   = '0;
      req_rect_width  = '0;
      req_rect_height = '0;
      req_line_length = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty screen, full fill, clear, clipping, zero sizes, spare codes
      send_word(CMD_READ,    0,  0,  0,  0,  0);
      send_word(CMD_FILL,    0,  0, 32, 32,  0);
      send_word(CMD_READ,   31, 31, 63, 63, 63);
      send_word(CMD_READ,    0,  0,  0,  0,  0);
      send_word(CMD_CLEAR,  31, 31, 63, 63, 63);
      send_word(CMD_READ,   31,  0,  0,  0,  0);
      // right and bottom edges fall off screen
      send_word(CMD_OUTLINE, 0,  0, 63, 63,  0);
      send_word(CMD_READ,    0,  0,  0,  0,  0);
      send_word(CMD_READ,    5,  0,  0,  0,  0);
      send_word(CMD_OUTLINE,30, 30,  2,  2,  0);
      send_word(CMD_READ,   30,  0,  0,  0,  0);
      send_word(CMD_READ,   31,  0,  0,  0,  0);
      send_word(CMD_HLINE,  31, 31,  0,  0, 63);
      send_word(CMD_HLINE,   3,  0,  0,  0,  0);
      send_word(CMD_VLINE,  10, 20,  0,  0, 63);
      send_word(CMD_VLINE,  12,  5,  0,  0,  0);
      send_word(CMD_FILL,    8,  4,  0,  5,  0);
      send_word(CMD_OUTLINE, 8,  4,  5,  0,  0);
      send_word(CMD_READ,    3,  0,  0,  0,  0);
      send_word(CMD_READ,   20,  0,  0,  0,  0);
      send_word(CMD_FILL,    8,  4,  5,  3,  0);
      send_word(CMD_READ,    9,  0,  0,  0,  0);
      send_word(CMD_SPARE_A, 9,  4,  5,  3,  7);
      send_word(CMD_SPARE_B,31, 31, 63, 63, 63);
      send_word(CMD_READ,   12,  0,  0,  0,  0);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         quiet = (i >= 400 && i < 550);
         cmd = pick_cmd();
         send_word(cmd, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 31)),
                   pick_size(), pick_size(), pick_size());
      end
      quiet = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
